FILE: design/ctt_pkg.sv
// Shared types and constants for the connection timeout table.
package ctt_pkg;

  // Input operation codes
  localparam logic [1:0] MODE_ARM    = 2'd0;
  localparam logic [1:0] MODE_DISARM = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // Result kinds
  localparam logic KIND_EXPIRE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Field widths
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned ACT_W   = 5;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned EXP_W   = 33;
  localparam int unsigned ORDER_W = 32;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned DIFF_W  = 22;

  // Slot ids are 4 bits wide, so at most this many slots can ever be armed
  localparam int unsigned MAX_ENTRIES = 16;

  // Interval conversion
  localparam logic [9:0]        MS_PER_SEC  = 10'd1000;
  localparam logic [EXP_W-1:0]  MS_SAT_SEC  = 33'd2147483;
  localparam logic [MS_W-1:0]   MS_INT_TOP  = 32'h7FFF_FFFF;
  localparam logic [MS_W-1:0]   MS_NONE     = 32'hFFFF_FFFF;

  // Ordering key of one timer: earlier expiry first, then larger age
  typedef struct packed {
    logic [EXP_W-1:0]   expiry;
    logic [ORDER_W-1:0] age;
  } ctt_key_t;

  // Verdict of the ordering unit on the scanned entry
  typedef struct packed {
    logic     take;
    logic     due;
    ctt_key_t key;
  } ctt_cmp_t;

endpackage

FILE: design/ctt_order_unit.sv
// Shared ordering unit: decides whether the scanned timer beats the best so far.
module ctt_order_unit (
  input  logic                          cand_armed_i,
  input  logic [ctt_pkg::EXP_W-1:0]     cand_expiry_i,
  input  logic [ctt_pkg::ORDER_W-1:0]   cand_order_i,
  input  logic [ctt_pkg::ORDER_W-1:0]   arm_counter_i,
  input  logic [ctt_pkg::TIME_W-1:0]    now_i,
  input  logic                          due_only_i,
  input  logic                          best_valid_i,
  input  ctt_pkg::ctt_key_t             best_key_i,
  output ctt_pkg::ctt_cmp_t             cmp_o
);
  import ctt_pkg::*;

  logic [ORDER_W-1:0] age;
  logic               due;
  logic               eligible;
  logic               ahead;

  // Age grows with every arm; wraps with the counter
  assign age = arm_counter_i - cand_order_i;

  // Due when expiry is at or before the current second
  assign due      = cand_armed_i && (cand_expiry_i <= {1'b0, now_i});
  assign eligible = cand_armed_i && (!due_only_i || due);

  // Strict ordering keeps the lower index on a full tie
  assign ahead = (cand_expiry_i < best_key_i.expiry) ||
                 ((cand_expiry_i == best_key_i.expiry) && (age > best_key_i.age));

  assign cmp_o.take       = eligible && (!best_valid_i || ahead);
  assign cmp_o.due        = due;
  assign cmp_o.key.expiry = cand_expiry_i;
  assign cmp_o.key.age    = age;

endmodule

FILE: design/connection_timeout_table_core.sv
// Top level of the connection timeout table: timer store, scan sequencer, result register.
//
// A table of up to 16 connection timers driven by a one-second tick. Arm and
// disarm do not raise in_stall_o. Every tick or query walks the table through one
// shared ordering unit, one entry per cycle, so the block holds in_stall_o high
// while it works: a query scans once and then forms its answer, and a tick
// rescans the table after each expiry report until every due slot is reported.
// Expiry reports come out in expiry order, ties in arming order, and every
// report of one tick carries the counts as they stand after that whole tick.
// A result waits in the output register while the next command is taken.
module connection_timeout_table_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         in_mode_i,
  input  logic [ctt_pkg::SLOT_W-1:0]         in_slot_id_i,
  input  logic [ctt_pkg::TMO_W-1:0]          in_timeout_sec_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               out_kind_o,
  output logic [ctt_pkg::SLOT_W-1:0]         out_expired_slot_o,
  output logic signed [ctt_pkg::MS_W-1:0]    out_next_interval_ms_o,
  output logic [ctt_pkg::ACT_W-1:0]          out_active_count_o,
  output logic [ctt_pkg::TIME_W-1:0]         out_timeout_total_o,
  output logic                               out_last_o
);
  import ctt_pkg::*;

  localparam int unsigned ENTRIES = (SLOTS < MAX_ENTRIES) ? SLOTS : MAX_ENTRIES;
  localparam int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_QCALC = 3'd4;
  localparam logic [2:0] ST_QOUT  = 3'd5;

  // Query answer selection
  localparam logic [1:0] QA_NONE = 2'd0;
  localparam logic [1:0] QA_ZERO = 2'd1;
  localparam logic [1:0] QA_SAT  = 2'd2;
  localparam logic [1:0] QA_MUL  = 2'd3;

  logic [2:0]         state_q, state_d;
  logic               is_query_q;
  logic               count_pass_q;
  logic [IW-1:0]      idx_q;
  logic               best_valid_q;
  logic [IW-1:0]      best_idx_q;
  ctt_key_t           best_key_q;
  logic [ACT_W-1:0]   due_cnt_q;
  logic [ACT_W-1:0]   n_q;
  logic [ACT_W-1:0]   emitted_q;
  logic [1:0]         qa_q;
  logic [DIFF_W-1:0]  diff_q;

  logic [TIME_W-1:0]  now_q;
  logic [ORDER_W-1:0] arm_counter_q;
  logic [TIME_W-1:0]  total_q;
  logic [ACT_W-1:0]   active_q;

  logic [ENTRIES-1:0] armed_q;
  logic [EXP_W-1:0]   expiry_mem [ENTRIES];
  logic [ORDER_W-1:0] order_mem  [ENTRIES];

  logic               out_valid_q;
  logic               out_kind_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [MS_W-1:0]    out_ms_q;
  logic [ACT_W-1:0]   out_active_q;
  logic [TIME_W-1:0]  out_total_q;
  logic               out_last_q;

  logic               in_beat;
  logic               slot_ok;
  logic [IW-1:0]      slot_idx;
  logic               out_free;
  logic               emit_beat;
  logic               qout_beat;
  logic               emit_last;
  logic               scan_end;
  logic [EXP_W-1:0]   diff;
  logic [MS_W-1:0]    ms_prod;
  logic [EXP_W-1:0]   cand_expiry;
  logic [ORDER_W-1:0] cand_order;
  ctt_cmp_t           cmp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign slot_ok    = ({1'b0, in_slot_id_i} < (SLOT_W + 1)'(ENTRIES));
  assign slot_idx   = in_slot_id_i[IW-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_beat  = (state_q == ST_EMIT) && out_free;
  assign qout_beat  = (state_q == ST_QOUT) && out_free;
  assign emit_last  = ((emitted_q + 1'b1) == n_q);
  assign scan_end   = (idx_q == IW'(ENTRIES - 1));

  // Store read port at the scan index
  assign cand_expiry = expiry_mem[idx_q];
  assign cand_order  = order_mem[idx_q];

  ctt_order_unit u_order (
    .cand_armed_i  (armed_q[idx_q]),
    .cand_expiry_i (cand_expiry),
    .cand_order_i  (cand_order),
    .arm_counter_i (arm_counter_q),
    .now_i         (now_q),
    .due_only_i    (!is_query_q),
    .best_valid_i  (best_valid_q),
    .best_key_i    (best_key_q),
    .cmp_o         (cmp)
  );

  // Query interval pieces
  assign diff    = best_key_q.expiry - {1'b0, now_q};
  assign ms_prod = MS_W'(diff_q) * MS_W'(MS_PER_SEC);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && ((in_mode_i == MODE_TICK) || (in_mode_i == MODE_QUERY))) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (is_query_q) state_d = ST_QCALC;
        else if (best_valid_q) state_d = ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_beat) state_d = emit_last ? ST_IDLE : ST_SCAN;
      end
      ST_QCALC: state_d = ST_QOUT;
      ST_QOUT: begin
        if (qout_beat) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      is_query_q    <= 1'b0;
      count_pass_q  <= 1'b0;
      idx_q         <= '0;
      best_valid_q  <= 1'b0;
      due_cnt_q     <= '0;
      n_q           <= '0;
      emitted_q     <= '0;
      now_q         <= '0;
      arm_counter_q <= '0;
      total_q       <= '0;
      active_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            idx_q        <= '0;
            best_valid_q <= 1'b0;
            due_cnt_q    <= '0;
            emitted_q    <= '0;
            count_pass_q <= 1'b1;
            is_query_q   <= (in_mode_i == MODE_QUERY);
            unique case (in_mode_i)
              MODE_ARM: begin
                if (slot_ok) begin
                  arm_counter_q <= arm_counter_q + 1'b1;
                  if (!armed_q[slot_idx]) active_q <= active_q + 1'b1;
                end
              end
              MODE_DISARM: begin
                if (slot_ok && armed_q[slot_idx]) active_q <= active_q - 1'b1;
              end
              MODE_TICK: begin
                if (now_q != '1) now_q <= now_q + 1'b1;
              end
              MODE_QUERY: ;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (cmp.take) best_valid_q <= 1'b1;
          if (count_pass_q && cmp.due) due_cnt_q <= due_cnt_q + 1'b1;
        end
        ST_EVAL: begin
          // Final counts are known after the first pass of a tick
          if (!is_query_q && count_pass_q) begin
            n_q          <= due_cnt_q;
            total_q      <= total_q + TIME_W'(due_cnt_q);
            active_q     <= active_q - due_cnt_q;
            count_pass_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (emit_beat) begin
            emitted_q    <= emitted_q + 1'b1;
            idx_q        <= '0;
            best_valid_q <= 1'b0;
          end
        end
        ST_QCALC: ;
        ST_QOUT: ;
        default: ;
      endcase
    end
  end

  // Best candidate and query answer payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && cmp.take) begin
      best_idx_q <= idx_q;
      best_key_q <= cmp.key;
    end
    if (state_q == ST_QCALC) begin
      diff_q <= diff[DIFF_W-1:0];
      priority if (!best_valid_q) begin
        qa_q <= QA_NONE;
      end else if (best_key_q.expiry <= {1'b0, now_q}) begin
        qa_q <= QA_ZERO;
      end else if (diff > MS_SAT_SEC) begin
        qa_q <= QA_SAT;
      end else begin
        qa_q <= QA_MUL;
      end
    end
  end

  // Armed flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else begin
      if (in_beat && slot_ok && (in_mode_i == MODE_ARM)) armed_q[slot_idx] <= 1'b1;
      if (in_beat && slot_ok && (in_mode_i == MODE_DISARM)) armed_q[slot_idx] <= 1'b0;
      if (emit_beat) armed_q[best_idx_q] <= 1'b0;
    end
  end

  // Expiry and arming-order store
  always_ff @(posedge clk_i) begin
    if (in_beat && slot_ok && (in_mode_i == MODE_ARM)) begin
      expiry_mem[slot_idx] <= {1'b0, now_q} + EXP_W'(in_timeout_sec_i);
      order_mem[slot_idx]  <= arm_counter_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_beat || qout_beat) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_beat) begin
      out_kind_q   <= KIND_EXPIRE;
      out_slot_q   <= SLOT_W'(best_idx_q);
      out_ms_q     <= '0;
      out_active_q <= active_q;
      out_total_q  <= total_q;
      out_last_q   <= emit_last;
    end else if (qout_beat) begin
      out_kind_q   <= KIND_QUERY;
      out_slot_q   <= '0;
      out_active_q <= active_q;
      out_total_q  <= total_q;
      out_last_q   <= 1'b1;
      unique case (qa_q)
        QA_NONE: out_ms_q <= MS_NONE;
        QA_ZERO: out_ms_q <= '0;
        QA_SAT:  out_ms_q <= MS_INT_TOP;
        QA_MUL:  out_ms_q <= ms_prod;
        default: out_ms_q <= MS_NONE;
      endcase
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_kind_o             = out_kind_q;
  assign out_expired_slot_o     = out_slot_q;
  assign out_next_interval_ms_o = $signed(out_ms_q);
  assign out_active_count_o     = out_active_q;
  assign out_timeout_total_o    = out_total_q;
  assign out_last_o             = out_last_q;

endmodule

FILE: design/ctt_checker.sv
// Port-level checks for the connection timeout table, bound to the top level.
module ctt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [1:0]                         in_mode_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               out_kind_o,
  input logic [ctt_pkg::SLOT_W-1:0]         out_expired_slot_o,
  input logic signed [ctt_pkg::MS_W-1:0]    out_next_interval_ms_o,
  input logic [ctt_pkg::ACT_W-1:0]          out_active_count_o,
  input logic [ctt_pkg::TIME_W-1:0]         out_timeout_total_o,
  input logic                               out_last_o
);
  import ctt_pkg::*;

  // A tick or query beat keeps the command side busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && ((in_mode_i == MODE_TICK) || (in_mode_i == MODE_QUERY)))
    |=> in_stall_o)
    else $error("tick or query beat did not occupy the block");

  // A query answer is a single, final result with no slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_QUERY)) |-> (out_last_o && (out_expired_slot_o == '0)))
    else $error("malformed query answer");

  // An expiry report carries a zero interval and at least one expiration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_EXPIRE))
    |-> ((out_next_interval_ms_o == '0) && (out_timeout_total_o != '0)))
    else $error("malformed expiry report");

  // The armed count never exceeds MAX_ENTRIES
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_active_count_o <= MAX_ENTRIES))
    else $error("active count out of range");

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
    |=> (out_valid_o && $stable(out_kind_o) && $stable(out_expired_slot_o)
         && $stable(out_next_interval_ms_o) && $stable(out_last_o)))
    else $error("stalled result beat changed");

endmodule

bind connection_timeout_table_core ctt_checker u_ctt_checker (.*);

FILE: bench/timer_table_checker.sv
// Checker for the connection timeout table: predicts every result beat and compares it.
module timer_table_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        in_mode_i,
  input  logic [ctt_pkg::SLOT_W-1:0]        in_slot_id_i,
  input  logic [ctt_pkg::TMO_W-1:0]         in_timeout_sec_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              out_kind_i,
  input  logic [ctt_pkg::SLOT_W-1:0]        out_expired_slot_i,
  input  logic signed [ctt_pkg::MS_W-1:0]   out_next_interval_ms_i,
  input  logic [ctt_pkg::ACT_W-1:0]         out_active_count_i,
  input  logic [ctt_pkg::TIME_W-1:0]        out_timeout_total_i,
  input  logic                              out_last_i,
  output int                                error_count_o,
  output int                                pending_o,
  output int                                results_o
);
  import ctt_pkg::*;

  typedef struct packed {
    logic                   kind;
    logic [SLOT_W-1:0]      slot;
    logic signed [MS_W-1:0] interval_ms;
    logic [ACT_W-1:0]       active;
    logic [TIME_W-1:0]      total;
    logic                   last;
  } timer_report_t;

  // Shadow copy of the timer table
  logic               slot_armed  [MAX_ENTRIES];
  logic [EXP_W-1:0]   slot_expiry [MAX_ENTRIES];
  logic [ORDER_W-1:0] slot_seq    [MAX_ENTRIES];
  logic [TIME_W-1:0]  now_sec;
  logic [ORDER_W-1:0] arm_seq;
  logic [TIME_W-1:0]  expired_cnt;

  timer_report_t expected_reports[$];
  int            mismatches;
  int            results_seen;

  assign error_count_o = mismatches;
  assign results_o     = results_seen;

  // Slot a leaves ahead of slot b: earlier expiry, then older arming, then lower index
  function automatic bit leaves_first(input int a, input int b);
    logic [ORDER_W-1:0] age_a;
    logic [ORDER_W-1:0] age_b;
    age_a = arm_seq - slot_seq[a];
    age_b = arm_seq - slot_seq[b];
    if (slot_expiry[a] != slot_expiry[b]) return slot_expiry[a] < slot_expiry[b];
    if (age_a != age_b) return age_a > age_b;
    return a < b;
  endfunction

  // First armed slot in expiry order, -1 when there is none
  function automatic int earliest_slot(input bit due_only);
    int best;
    best = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_armed[i] && !(due_only && slot_expiry[i] > {1'b0, now_sec})) begin
        if (best < 0 || leaves_first(i, best)) best = i;
      end
    end
    return best;
  endfunction

  function automatic logic [ACT_W-1:0] armed_count();
    logic [ACT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) if (slot_armed[i]) n++;
    return n;
  endfunction

  // Apply one command beat to the shadow table and queue the reports it causes
  task automatic predict_timer_command(input logic [1:0] mode, input logic [SLOT_W-1:0] slot,
                                       input logic [TMO_W-1:0] tmo);
    int               picked[MAX_ENTRIES];
    int               n;
    int               s;
    logic [EXP_W-1:0] diff;
    logic [MS_W-1:0]  ms;
    timer_report_t    rep;
    n = 0;
    case (mode)
      MODE_ARM: begin
        slot_armed[slot]  = 1'b1;
        slot_expiry[slot] = {1'b0, now_sec} + EXP_W'(tmo);
        slot_seq[slot]    = arm_seq;
        arm_seq++;
      end
      MODE_DISARM: slot_armed[slot] = 1'b0;
      MODE_TICK: begin
        if (now_sec != '1) now_sec++;
        while (n < MAX_ENTRIES) begin
          s = earliest_slot(1'b1);
          if (s < 0) break;
          slot_armed[s] = 1'b0;
          expired_cnt++;
          picked[n] = s;
          n++;
        end
        // counts in every report are those after the whole tick
        for (int k = 0; k < n; k++) begin
          rep.kind        = KIND_EXPIRE;
          rep.slot        = picked[k][SLOT_W-1:0];
          rep.interval_ms = '0;
          rep.active      = armed_count();
          rep.total       = expired_cnt;
          rep.last        = (k == n - 1);
          expected_reports = {expected_reports, rep};
        end
      end
      default: begin
        s = earliest_slot(1'b0);
        if (s < 0) begin
          ms = MS_NONE;
        end else if (slot_expiry[s] <= {1'b0, now_sec}) begin
          ms = '0;
        end else begin
          diff = slot_expiry[s] - {1'b0, now_sec};
          if (diff > MS_SAT_SEC) ms = MS_INT_TOP;
          else ms = MS_W'(diff * MS_PER_SEC);
        end
        rep.kind        = KIND_QUERY;
        rep.slot        = '0;
        rep.interval_ms = ms;
        rep.active      = armed_count();
        rep.total       = expired_cnt;
        rep.last        = 1'b1;
        expected_reports = {expected_reports, rep};
      end
    endcase
  endtask

  // Compare result beats, then predict from command beats
  always @(posedge clk_i or negedge rst_ni) begin
    timer_report_t got;
    timer_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_armed[i]  = 1'b0;
        slot_expiry[i] = '0;
        slot_seq[i]    = '0;
      end
      now_sec      = '0;
      arm_seq      = '0;
      expired_cnt  = '0;
      mismatches   = 0;
      results_seen = 0;
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{out_kind_i, out_expired_slot_i, out_next_interval_ms_i, out_active_count_i,
                out_timeout_total_i, out_last_i};
        results_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result kind=%0d slot=%0d ms=%0d active=%0d total=%0d",
                     got.kind, got.slot, got.interval_ms, got.active, got.total);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d expected kind=%0d slot=%0d ms=%0d active=%0d",
                       results_seen, want.kind, want.slot, want.interval_ms, want.active);
              $display("       total=%0d last=%0d, got kind=%0d slot=%0d ms=%0d active=%0d",
                       want.total, want.last, got.kind, got.slot, got.interval_ms,
                       got.active);
              $display("       total=%0d last=%0d", got.total, got.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_timer_command(in_mode_i, in_slot_id_i, in_timeout_sec_i);
      pending_o <= expected_reports.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the connection timeout table bench: clock, reset, command stimulus and verdict.
module testbench;
  import ctt_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_stall;
  logic [1:0]             cmd_mode  = MODE_QUERY;
  logic [SLOT_W-1:0]      cmd_slot  = '0;
  logic [TMO_W-1:0]       cmd_tmo   = '0;
  logic                   rpt_valid;
  logic                   rpt_stall = 1'b0;
  logic                   rpt_kind;
  logic [SLOT_W-1:0]      rpt_slot;
  logic signed [MS_W-1:0] rpt_ms;
  logic [ACT_W-1:0]       rpt_active;
  logic [TIME_W-1:0]      rpt_total;
  logic                   rpt_last;

  int errors;
  int pending;
  int results;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mode_sent[4]   = '{0, 0, 0, 0};

  connection_timeout_table_core #(.SLOTS(16)) dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (cmd_valid),
    .in_stall_o             (cmd_stall),
    .in_mode_i              (cmd_mode),
    .in_slot_id_i           (cmd_slot),
    .in_timeout_sec_i       (cmd_tmo),
    .out_valid_o            (rpt_valid),
    .out_stall_i            (rpt_stall),
    .out_kind_o             (rpt_kind),
    .out_expired_slot_o     (rpt_slot),
    .out_next_interval_ms_o (rpt_ms),
    .out_active_count_o     (rpt_active),
    .out_timeout_total_o    (rpt_total),
    .out_last_o             (rpt_last)
  );

  timer_table_checker u_checker (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (cmd_valid),
    .in_stall_i             (cmd_stall),
    .in_mode_i              (cmd_mode),
    .in_slot_id_i           (cmd_slot),
    .in_timeout_sec_i       (cmd_tmo),
    .out_valid_i            (rpt_valid),
    .out_stall_i            (rpt_stall),
    .out_kind_i             (rpt_kind),
    .out_expired_slot_i     (rpt_slot),
    .out_next_interval_ms_i (rpt_ms),
    .out_active_count_i     (rpt_active),
    .out_timeout_total_i    (rpt_total),
    .out_last_i             (rpt_last),
    .error_count_o          (errors),
    .pending_o              (pending),
    .results_o              (results)
  );

  always #2 clk = ~clk;

  // Result side stalls at random
  always @(posedge clk) rpt_stall <= ($urandom_range(99) < recv_stall_pct);

  // One command beat, with random idle cycles in front of it
  task automatic send_command(input logic [1:0] mode, input logic [SLOT_W-1:0] slot,
                              input logic [TMO_W-1:0] tmo);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_mode  <= mode;
    cmd_slot  <= slot;
    cmd_tmo   <= tmo;
    do @(posedge clk); while (cmd_stall);
    mode_sent[mode]++;
  endtask

  // Hold the command side until every expected report has come back
  task automatic drain_reports();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly short timeouts so slots keep expiring; a few full-range ones
  task automatic random_commands(input int count);
    int               r;
    logic [1:0]       mode;
    logic [TMO_W-1:0] tmo;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 40) mode = MODE_ARM;
      else if (r < 55) mode = MODE_DISARM;
      else if (r < 85) mode = MODE_TICK;
      else mode = MODE_QUERY;
      if ($urandom_range(99) < 85) tmo = TMO_W'($urandom_range(6));
      else tmo = TMO_W'($urandom_range(16'hFFFF));
      send_command(mode, SLOT_W'($urandom_range(15)), tmo);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty query, far expiry, ties, re-arm, idle disarm, full table expiry
    send_idle_pct = 30;
    recv_stall_pct <= 87;
    send_command(MODE_QUERY, 4'd0, 16'd0);
    send_command(MODE_ARM, 4'd15, 16'hFFFF);
    send_command(MODE_QUERY, 4'd0, 16'd0);
    send_command(MODE_ARM, 4'd3, 16'd2);
    send_command(MODE_ARM, 4'd5, 16'd2);
    send_command(MODE_ARM, 4'd3, 16'd2);
    send_command(MODE_DISARM, 4'd7, 16'd0);
    send_command(MODE_TICK, 4'd0, 16'd0);
    send_command(MODE_QUERY, 4'd0, 16'd0);
    send_command(MODE_TICK, 4'd0, 16'd0);
    for (int i = 15; i >= 0; i--) send_command(MODE_ARM, 4'(i), 16'd0);
    send_command(MODE_QUERY, 4'd0, 16'd0);
    send_command(MODE_TICK, 4'd0, 16'd0);
    send_command(MODE_QUERY, 4'd0, 16'd0);

    // Random: receiver slow, then sender slow, then both at full rate
    random_commands(150);
    drain_reports();
    send_idle_pct = 87;
    recv_stall_pct <= 30;
    random_commands(150);
    drain_reports();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    random_commands(145);

    drain_reports();
    repeat (400) @(posedge clk);

    $display("Covered %0d arm, %0d disarm, %0d tick and %0d query commands,",
             mode_sent[MODE_ARM], mode_sent[MODE_DISARM], mode_sent[MODE_TICK],
             mode_sent[MODE_QUERY]);
    $display("checking %0d result beats under three idle and stall mixes.", results);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
